### rtl/hse_pkg.sv
// ----------------------------------------------------------------------------
// hse_pkg
// Shared types and constants for the heap sort engine.
// ----------------------------------------------------------------------------
`default_nettype none

package hse_pkg;

    // default capacity of the element store
    localparam int MAX_ITEMS_DEF = 64;
    // element width
    localparam int DATA_W = 32;

    // one input word
    typedef struct packed {
        logic signed [DATA_W-1:0] value;
        logic                     last;
    } t_in_item;

    // one result word
    typedef struct packed {
        logic signed [DATA_W-1:0] sorted_value;
        logic                     last_res;
        logic                     dropped;
    } t_out_item;

endpackage

`default_nettype wire

### rtl/heap_sort_engine.sv
// ----------------------------------------------------------------------------
// heap_sort_engine
// Collects a set of signed 32-bit values and returns them in ascending order.
// ----------------------------------------------------------------------------
// Usage:
//   Input: drive i_item and raise start; the word is taken on a clock edge
//   where start is high and busy is low. Words are written into a store of
//   MAX_ITEMS entries; words that arrive while it is full are discarded and
//   the run is flagged as dropped. A word with last set ends the set.
//   After the last word, busy stays high while the store is heapified and
//   sorted in place by one sift-down sequencer around a single RAM read
//   port: at each tree level it reads the left child, reads the right
//   child, then compares and moves the larger child up.
//   Output: the results then leave one per cycle, each valid for exactly
//   one cycle while o_strobe is high; the receiver cannot stall them.
//   last_res marks the final word, dropped is set on every word of a run
//   that lost elements.
//   Reset (i_rst_n low, synchronous) empties the set and returns to idle.
//   The store contents are not cleared; only written entries are ever read.
// ----------------------------------------------------------------------------
`default_nettype none

module heap_sort_engine #(
    parameter int MAX_ITEMS = hse_pkg::MAX_ITEMS_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire hse_pkg::t_in_item i_item,
    output logic                   o_strobe,
    output hse_pkg::t_out_item     o_result
);

    import hse_pkg::*;

    localparam int AW = $clog2(MAX_ITEMS);
    localparam int CW = $clog2(MAX_ITEMS + 1);
    localparam int IW = CW + 1;

    // sequencer states
    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_BINIT  = 4'd1;
    localparam logic [3:0] ST_RDV    = 4'd2;
    localparam logic [3:0] ST_WTV    = 4'd3;
    localparam logic [3:0] ST_SDL    = 4'd4;
    localparam logic [3:0] ST_SDR    = 4'd5;
    localparam logic [3:0] ST_SDC    = 4'd6;
    localparam logic [3:0] ST_SINIT  = 4'd7;
    localparam logic [3:0] ST_SW0    = 4'd8;
    localparam logic [3:0] ST_SWE    = 4'd9;
    localparam logic [3:0] ST_SWW    = 4'd10;
    localparam logic [3:0] ST_OUT    = 4'd11;

    // control registers
    logic [3:0]    r_state, n_state;
    logic [CW-1:0] r_count, n_count;
    logic          r_ovf, n_ovf;
    logic [AW-1:0] r_node, n_node;
    logic [CW-1:0] r_len, n_len;
    logic [CW-1:0] r_k, n_k;
    logic [AW-1:0] r_end, n_end;
    logic          r_phase, n_phase;
    logic [CW-1:0] r_oi, n_oi;
    logic          r_pend, n_pend;
    logic          r_plast, n_plast;
    logic          r_pdrop, n_pdrop;

    // payload registers
    logic signed [DATA_W-1:0] r_v, n_v;
    logic signed [DATA_W-1:0] r_lv, n_lv;
    logic signed [DATA_W-1:0] r_t, n_t;

    // RAM interface
    logic                     ram_we;
    logic [AW-1:0]            ram_waddr;
    logic signed [DATA_W-1:0] ram_wdata;
    logic [AW-1:0]            ram_raddr;
    logic [DATA_W-1:0]        ram_rdata;
    logic signed [DATA_W-1:0] rdata_s;

    // child indexes and compare
    logic [IW-1:0]            lc_idx;
    logic [IW-1:0]            rc_idx;
    logic                     lc_in;
    logic                     rc_in;
    logic                     lc_gt;
    logic signed [DATA_W-1:0] best_v;
    logic                     rc_gt;
    logic                     sift_done;

    hse_ram #(
        .WIDTH(DATA_W),
        .DEPTH(MAX_ITEMS)
    ) u_store (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    assign rdata_s = $signed(ram_rdata);

    // heap child positions of the current node
    assign lc_idx = IW'({r_node, 1'b1});
    assign rc_idx = lc_idx + IW'(1);
    assign lc_in  = lc_idx < IW'(r_len);
    assign rc_in  = rc_idx < IW'(r_len);

    // shared compare unit: larger of held value and left child, then right
    assign lc_gt  = r_lv > r_v;
    assign best_v = lc_gt ? r_lv : r_v;
    assign rc_gt  = rc_in && (rdata_s > best_v);

    assign busy     = r_state != ST_IDLE;
    assign o_strobe = r_pend;

    always_comb begin
        o_result.sorted_value = rdata_s;
        o_result.last_res     = r_plast;
        o_result.dropped      = r_pdrop;
    end

    // sequencer
    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_ovf     = r_ovf;
        n_node    = r_node;
        n_len     = r_len;
        n_k       = r_k;
        n_end     = r_end;
        n_phase   = r_phase;
        n_oi      = r_oi;
        n_pend    = 1'b0;
        n_plast   = r_plast;
        n_pdrop   = r_pdrop;
        n_v       = r_v;
        n_lv      = r_lv;
        n_t       = r_t;
        ram_we    = 1'b0;
        ram_waddr = r_node;
        ram_wdata = r_v;
        ram_raddr = '0;
        sift_done = 1'b0;

        unique case (r_state)
            ST_IDLE: begin
                if (start) begin
                    if (r_count < CW'(MAX_ITEMS)) begin
                        ram_we    = 1'b1;
                        ram_waddr = r_count[AW-1:0];
                        ram_wdata = i_item.value;
                        n_count   = r_count + CW'(1);
                    end else begin
                        n_ovf = 1'b1;
                    end
                    if (i_item.last) begin
                        n_state = ST_BINIT;
                    end
                end
            end
            // heap build: sift every inner node, bottom up
            ST_BINIT: begin
                n_len   = r_count;
                n_k     = r_count >> 1;
                n_phase = 1'b0;
                if ((r_count >> 1) == '0) begin
                    n_state = ST_SINIT;
                end else begin
                    n_node  = AW'((r_count >> 1) - CW'(1));
                    n_state = ST_RDV;
                end
            end
            ST_RDV: begin
                ram_raddr = r_node;
                n_state   = ST_WTV;
            end
            ST_WTV: begin
                n_v     = rdata_s;
                n_state = ST_SDL;
            end
            // sift-down: read left child, or place the held value
            ST_SDL: begin
                ram_raddr = lc_idx[AW-1:0];
                if (!lc_in) begin
                    ram_we    = 1'b1;
                    sift_done = 1'b1;
                end else begin
                    n_state = ST_SDR;
                end
            end
            ST_SDR: begin
                n_lv      = rdata_s;
                ram_raddr = rc_idx[AW-1:0];
                n_state   = ST_SDC;
            end
            // move the larger child up, or place the held value
            ST_SDC: begin
                ram_we = 1'b1;
                if (rc_gt) begin
                    ram_wdata = rdata_s;
                    n_node    = rc_idx[AW-1:0];
                    n_state   = ST_SDL;
                end else if (lc_gt) begin
                    ram_wdata = r_lv;
                    n_node    = lc_idx[AW-1:0];
                    n_state   = ST_SDL;
                end else begin
                    sift_done = 1'b1;
                end
            end
            // sort phase: swap root with the end of the heap
            ST_SINIT: begin
                n_phase = 1'b1;
                if (r_count <= CW'(1)) begin
                    n_oi    = '0;
                    n_state = ST_OUT;
                end else begin
                    n_end   = AW'(r_count - CW'(1));
                    n_state = ST_SW0;
                end
            end
            ST_SW0: begin
                ram_raddr = '0;
                n_state   = ST_SWE;
            end
            ST_SWE: begin
                n_t       = rdata_s;
                ram_raddr = r_end;
                n_state   = ST_SWW;
            end
            ST_SWW: begin
                ram_we    = 1'b1;
                ram_waddr = r_end;
                ram_wdata = r_t;
                n_v       = rdata_s;
                n_node    = '0;
                n_len     = CW'(r_end);
                n_state   = ST_SDL;
            end
            // stream the sorted store out, one word a cycle
            ST_OUT: begin
                ram_raddr = r_oi[AW-1:0];
                n_pend    = 1'b1;
                n_plast   = r_oi == (r_count - CW'(1));
                n_pdrop   = r_ovf;
                n_oi      = r_oi + CW'(1);
                if (r_oi == (r_count - CW'(1))) begin
                    n_count = '0;
                    n_ovf   = 1'b0;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        // next sift after one finishes
        if (sift_done) begin
            if (!r_phase) begin
                if (r_k == CW'(1)) begin
                    n_state = ST_SINIT;
                end else begin
                    n_k     = r_k - CW'(1);
                    n_node  = AW'(r_k - CW'(2));
                    n_state = ST_RDV;
                end
            end else begin
                if (r_end == AW'(1)) begin
                    n_oi    = '0;
                    n_state = ST_OUT;
                end else begin
                    n_end   = r_end - AW'(1);
                    n_state = ST_SW0;
                end
            end
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_count <= '0;
            r_ovf   <= 1'b0;
            r_pend  <= 1'b0;
            r_phase <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_ovf   <= n_ovf;
            r_pend  <= n_pend;
            r_phase <= n_phase;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_node  <= n_node;
        r_len   <= n_len;
        r_k     <= n_k;
        r_end   <= n_end;
        r_oi    <= n_oi;
        r_plast <= n_plast;
        r_pdrop <= n_pdrop;
        r_v     <= n_v;
        r_lv    <= n_lv;
        r_t     <= n_t;
    end

endmodule

`default_nettype wire

### rtl/hse_ram.sv
// ----------------------------------------------------------------------------
// hse_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module hse_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

### tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for heap_sort_engine. A table of directed words covers
// single-element sets, the signed extremes, equal values and reversed input.
// It is followed by random sets, including a full store and sets that
// overflow it. Every accepted word goes through a behavioral copy of the
// set store, and the sorted run it predicts, or the results typed into the
// table, is matched against each result word as it comes out.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import hse_pkg::*;

    localparam int CLK_PERIOD = 8;
    localparam int CAP        = MAX_ITEMS_DEF;
    localparam int RAND_ITEMS = 250;
    localparam int DRAIN      = 200;

    localparam logic signed [DATA_W-1:0] S_MIN = {1'b1, {(DATA_W-1){1'b0}}};
    localparam logic signed [DATA_W-1:0] S_MAX = {1'b0, {(DATA_W-1){1'b1}}};

    // one row of the directed table; n_typed > 0 means the results are typed in
    typedef struct {
        t_in_item  word;
        int        n_typed;
        t_out_item e0;
        t_out_item e1;
    } t_dir_row;

    logic      i_clk   = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      start   = 1'b0;
    t_in_item  i_item  = '0;
    logic      busy;
    logic      o_strobe;
    t_out_item o_result;

    // model of the set being collected
    logic signed [DATA_W-1:0] set_vals[$];
    bit                       set_overflow = 1'b0;
    t_out_item                sorted_run[$];

    // result words still owed by the block
    t_out_item expected_words[$];
    int        errors  = 0;
    bit        no_gaps = 1'b0;
    t_dir_row  dir_rows[$];

    heap_sort_engine uut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_item   (i_item),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

    always #(CLK_PERIOD/2) i_clk = ~i_clk;

    function automatic t_out_item res(input logic signed [DATA_W-1:0] v,
                                      input logic l, input logic d);
        t_out_item r;
        r.sorted_value = v;
        r.last_res     = l;
        r.dropped      = d;
        return r;
    endfunction

    function automatic t_dir_row row(input logic signed [DATA_W-1:0] v, input logic l,
                                     input int nt, input t_out_item e0,
                                     input t_out_item e1);
        t_dir_row r;
        r.word.value = v;
        r.word.last  = l;
        r.n_typed    = nt;
        r.e0         = e0;
        r.e1         = e1;
        return r;
    endfunction

    // random value: mostly full range, some near zero for duplicates, some extremes
    function automatic logic signed [DATA_W-1:0] draw_value();
        case ($urandom_range(0, 5))
            0: return $urandom_range(0, 15) - 8;
            1: begin
                case ($urandom_range(0, 3))
                    0: return S_MIN;
                    1: return S_MAX;
                    2: return '0;
                    default: return '1;
                endcase
            end
            default: return $urandom;
        endcase
    endfunction

    // store or drop one word; on the last word sort the set into sorted_run
    task automatic absorb_word(input t_in_item w);
        logic signed [DATA_W-1:0] key;
        int i;
        int j;
        t_out_item r;
        sorted_run.delete();
        if (set_vals.size() < CAP) begin
            set_vals.push_back(w.value);
        end else begin
            set_overflow = 1'b1;
        end
        if (w.last) begin
            // insertion sort, signed order
            for (i = 1; i < set_vals.size(); i++) begin
                key = set_vals[i];
                j = i - 1;
                while (j >= 0 && set_vals[j] > key) begin
                    set_vals[j+1] = set_vals[j];
                    j--;
                end
                set_vals[j+1] = key;
            end
            for (i = 0; i < set_vals.size(); i++) begin
                r.sorted_value = set_vals[i];
                r.last_res     = (i == set_vals.size() - 1);
                r.dropped      = set_overflow;
                sorted_run.push_back(r);
            end
            set_vals.delete();
            set_overflow = 1'b0;
        end
    endtask

    // present one word after a random gap and hold it until taken
    task automatic send_word(input t_in_item w);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 4);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start  <= 1'b1;
        i_item <= w;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    task automatic run_word(input t_in_item w, input int n_typed,
                            input t_out_item e0, input t_out_item e1);
        int k;
        send_word(w);
        absorb_word(w);
        if (n_typed == 0) begin
            for (k = 0; k < sorted_run.size(); k++) expected_words.push_back(sorted_run[k]);
        end else begin
            expected_words.push_back(e0);
            if (n_typed > 1) expected_words.push_back(e1);
        end
    endtask

    // result checker
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_strobe) begin
            if (expected_words.size() == 0) begin
                $display("%0t: result word with none expected: value %0d last %0b dropped %0b",
                         $time, o_result.sorted_value, o_result.last_res, o_result.dropped);
                errors++;
            end else begin
                want = expected_words.pop_front();
                if (o_result.sorted_value !== want.sorted_value) begin
                    $display("%0t: sorted_value expected %0d actual %0d",
                             $time, want.sorted_value, o_result.sorted_value);
                    errors++;
                end
                if (o_result.last_res !== want.last_res) begin
                    $display("%0t: last_res expected %0b actual %0b",
                             $time, want.last_res, o_result.last_res);
                    errors++;
                end
                if (o_result.dropped !== want.dropped) begin
                    $display("%0t: dropped expected %0b actual %0b",
                             $time, want.dropped, o_result.dropped);
                    errors++;
                end
            end
        end
    end

    // stimulus
    initial begin
        t_out_item nil;
        t_in_item  w;
        int        i;
        int        k;
        int        sent;
        int        set_idx;
        int        set_size;

        nil = '0;

        // single-element sets: result is the element itself
        dir_rows.push_back(row(S_MIN, 1'b1, 1, res(S_MIN, 1'b1, 1'b0), nil));
        dir_rows.push_back(row(S_MAX, 1'b1, 1, res(S_MAX, 1'b1, 1'b0), nil));
        dir_rows.push_back(row('0, 1'b1, 1, res('0, 1'b1, 1'b0), nil));
        dir_rows.push_back(row('1, 1'b1, 1, res('1, 1'b1, 1'b0), nil));
        // two extremes, given high first
        dir_rows.push_back(row(S_MAX, 1'b0, 0, nil, nil));
        dir_rows.push_back(row(S_MIN, 1'b1, 2, res(S_MIN, 1'b0, 1'b0),
                               res(S_MAX, 1'b1, 1'b0)));
        // equal values
        dir_rows.push_back(row(5, 1'b0, 0, nil, nil));
        dir_rows.push_back(row(5, 1'b0, 0, nil, nil));
        dir_rows.push_back(row(5, 1'b1, 0, nil, nil));
        // mixed signs with both extremes
        dir_rows.push_back(row(3, 1'b0, 0, nil, nil));
        dir_rows.push_back(row(-7, 1'b0, 0, nil, nil));
        dir_rows.push_back(row(S_MAX, 1'b0, 0, nil, nil));
        dir_rows.push_back(row(1, 1'b0, 0, nil, nil));
        dir_rows.push_back(row(S_MIN, 1'b1, 0, nil, nil));
        // reversed input
        for (i = 7; i >= 0; i--) dir_rows.push_back(row(i, i == 0, 0, nil, nil));
        // neighbors of the extremes
        dir_rows.push_back(row(S_MIN + 1, 1'b0, 0, nil, nil));
        dir_rows.push_back(row(S_MAX - 1, 1'b0, 0, nil, nil));
        dir_rows.push_back(row(-2, 1'b1, 0, nil, nil));

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table
        for (i = 0; i < dir_rows.size(); i++) begin
            run_word(dir_rows[i].word, dir_rows[i].n_typed, dir_rows[i].e0, dir_rows[i].e1);
        end

        // random sets: mostly small, one exactly full, two overflowing
        sent    = 0;
        set_idx = 0;
        while (sent < RAND_ITEMS) begin
            case (set_idx)
                1: set_size = CAP;
                4: set_size = CAP + 1;
                7: set_size = CAP + 2;
                default: set_size = $urandom_range(1, 10);
            endcase
            no_gaps = ($urandom_range(0, 3) == 0);
            for (k = 0; k < set_size; k++) begin
                w.value = draw_value();
                w.last  = (k == set_size - 1);
                run_word(w, 0, nil, nil);
                sent++;
            end
            set_idx++;
        end
        start <= 1'b0;

        // wait for the last sorted run, then watch for stray words
        while (expected_words.size() != 0) @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);

        if (errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    // watchdog
    initial begin
        #2_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule

`default_nettype wire
